// ===== rtl/three_axis_step_pulse_generator_defines.svh =====
// Assertion macros shared by the step pulse generator RTL
`ifndef THREE_AXIS_STEP_PULSE_GENERATOR_DEFINES_SVH
`define THREE_AXIS_STEP_PULSE_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled in reset
`define TSPG_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled in reset
`define TSPG_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define TSPG_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define TSPG_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

// ===== rtl/tspg_pkg.sv =====
// Types and constants of the three-axis step pulse generator
package tspg_pkg;

  localparam int POS_WIDTH_DEF  = 32;
  localparam int TIME_WIDTH_DEF = 32;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // status codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DONE  = 3'd2;
  localparam logic [2:0] ST_LIMIT = 3'd3;
  localparam logic [2:0] ST_ESTOP = 3'd4;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [31:0] target_x;
    logic [31:0] target_y;
    logic [31:0] target_z;
    logic [31:0] period_x;
    logic [31:0] period_y;
    logic [31:0] period_z;
    logic        estop;
    logic        limit_x_n;
    logic        limit_y_n;
    logic        limit_z_n;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  limit_axis;
    logic        step_x;
    logic        step_y;
    logic        step_z;
    logic        dir_x;
    logic        dir_y;
    logic        dir_z;
    logic        backoff_pulse;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } out_word_t;

  // top level to axis
  typedef struct packed {
    logic start;    // load a new move
    logic serve;    // tick may serve this axis
    logic limit_n;  // active-low limit switch
  } axis_ctrl_t;

  // axis to top level
  typedef struct packed {
    logic hit;        // limit reached on a falling edge
    logic on_target;  // next position equals next target
    logic dir;        // next direction line
    logic step;       // next step line
  } axis_stat_t;

endpackage

// ===== rtl/tspg_axis.sv =====
// One axis: position, target, period, next-edge time, direction and step line
module tspg_axis #(
  parameter int POS_WIDTH  = tspg_pkg::POS_WIDTH_DEF,
  parameter int TIME_WIDTH = tspg_pkg::TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tspg_pkg::axis_ctrl_t   ctrl_i,
  input  logic [POS_WIDTH-1:0]   target_i,
  input  logic [TIME_WIDTH-1:0]  period_i,
  input  logic [TIME_WIDTH-1:0]  tick_clock_i,
  output tspg_pkg::axis_stat_t   stat_o,
  output logic [POS_WIDTH-1:0]   pos_o
);

  logic [POS_WIDTH-1:0]  pos_r, pos_nxt;
  logic [POS_WIDTH-1:0]  target_r, target_nxt;
  logic [TIME_WIDTH-1:0] period_r, period_nxt;
  logic [TIME_WIDTH-1:0] edge_r, edge_nxt;
  logic                  dir_r, dir_nxt;
  logic                  step_r, step_nxt;
  logic                  due;
  logic                  hit;

  // due when the clock reached the next edge and the axis is short of target
  assign due = (tick_clock_i >= edge_r) && (pos_r != target_r);
  assign hit = ctrl_i.serve && due && step_r && !ctrl_i.limit_n;

  // next state
  always_comb begin
    pos_nxt    = pos_r;
    target_nxt = target_r;
    period_nxt = period_r;
    edge_nxt   = edge_r;
    dir_nxt    = dir_r;
    step_nxt   = step_r;
    if (ctrl_i.start) begin
      target_nxt = target_i;
      period_nxt = period_i;
      edge_nxt   = '0;
      dir_nxt    = (target_i > pos_r);
    end else if (ctrl_i.serve && due) begin
      if (step_r) begin
        // falling edge: back off on a limit, else count
        step_nxt = 1'b0;
        if (!ctrl_i.limit_n) begin
          dir_nxt = ~dir_r;
        end else begin
          pos_nxt  = dir_r ? (pos_r + POS_WIDTH'(1)) : (pos_r - POS_WIDTH'(1));
          edge_nxt = edge_r + period_r;
        end
      end else begin
        step_nxt = 1'b1;
        edge_nxt = edge_r + period_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      target_r <= '0;
      period_r <= '0;
      edge_r   <= '0;
      dir_r    <= 1'b0;
      step_r   <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      target_r <= target_nxt;
      period_r <= period_nxt;
      edge_r   <= edge_nxt;
      dir_r    <= dir_nxt;
      step_r   <= step_nxt;
    end
  end

  assign stat_o.hit       = hit;
  assign stat_o.on_target = (pos_nxt == target_nxt);
  assign stat_o.dir       = dir_nxt;
  assign stat_o.step      = step_nxt;
  assign pos_o            = pos_nxt;

endmodule

// ===== rtl/three_axis_step_pulse_generator.sv =====
// Three-axis step pulse generator top level
//
//   channel  | direction | handshake          | word
//   in_      | input     | in_valid/in_stall  | tspg_pkg::in_word_t (start or tick)
//   out_     | output    | out_valid/out_stall| tspg_pkg::out_word_t (one per input)
//
// A word is taken into the input register, processed against the axis state and written
// to the output register; one word per cycle while the output is not held.
// The rate is set by the single pass of three compare-and-count axes.
// rst_n is synchronous: all axis state, the tick clock and the move flag clear to zero.
// A held output stalls the input register, which then raises in_stall.
module three_axis_step_pulse_generator #(
  parameter int POS_WIDTH  = tspg_pkg::POS_WIDTH_DEF,
  parameter int TIME_WIDTH = tspg_pkg::TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tspg_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tspg_pkg::out_word_t  out_word
);

`include "three_axis_step_pulse_generator_defines.svh"

  logic                 in_valid_r;
  tspg_pkg::in_word_t   in_word_r;
  logic                 out_valid_r;
  tspg_pkg::out_word_t  out_word_r, out_word_nxt;
  logic                 move_active_r, move_active_nxt;
  logic [TIME_WIDTH-1:0] tick_clock_r, tick_clock_nxt;

  logic out_free;
  logic proc;
  logic is_start;
  logic is_tick;
  logic run_go;
  logic any_hit;
  logic all_on;
  logic [2:0] hit_vec;

  tspg_pkg::axis_ctrl_t ctrl_x, ctrl_y, ctrl_z;
  tspg_pkg::axis_stat_t stat_x, stat_y, stat_z;
  logic [POS_WIDTH-1:0] pos_x, pos_y, pos_z;
  logic [POS_WIDTH-1:0] tgt_x, tgt_y, tgt_z;
  logic [TIME_WIDTH-1:0] per_x, per_y, per_z;
  logic [POS_WIDTH+31:0] tgt_x_ext, tgt_y_ext, tgt_z_ext;
  logic [TIME_WIDTH+31:0] per_x_ext, per_y_ext, per_z_ext;
  logic [POS_WIDTH+31:0] pos_x_ext, pos_y_ext, pos_z_ext;

  // handshake: output register frees when empty or taken
  assign out_free  = !out_valid_r || !out_stall;
  assign proc      = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
  end

  // fit 32-bit fields to the configured widths
  assign tgt_x_ext = {POS_WIDTH'(0), in_word_r.target_x};
  assign tgt_y_ext = {POS_WIDTH'(0), in_word_r.target_y};
  assign tgt_z_ext = {POS_WIDTH'(0), in_word_r.target_z};
  assign per_x_ext = {TIME_WIDTH'(0), in_word_r.period_x};
  assign per_y_ext = {TIME_WIDTH'(0), in_word_r.period_y};
  assign per_z_ext = {TIME_WIDTH'(0), in_word_r.period_z};
  assign tgt_x = tgt_x_ext[POS_WIDTH-1:0];
  assign tgt_y = tgt_y_ext[POS_WIDTH-1:0];
  assign tgt_z = tgt_z_ext[POS_WIDTH-1:0];
  assign per_x = per_x_ext[TIME_WIDTH-1:0];
  assign per_y = per_y_ext[TIME_WIDTH-1:0];
  assign per_z = per_z_ext[TIME_WIDTH-1:0];

  // request decode; X, Y, Z served in order, a limit hit stops later axes
  assign is_start = proc && (in_word_r.req_type == tspg_pkg::REQ_START);
  assign is_tick  = proc && (in_word_r.req_type == tspg_pkg::REQ_TICK);
  assign run_go   = is_tick && move_active_r && !in_word_r.estop;

  assign ctrl_x.start   = is_start;
  assign ctrl_x.serve   = run_go;
  assign ctrl_x.limit_n = in_word_r.limit_x_n;
  assign ctrl_y.start   = is_start;
  assign ctrl_y.serve   = run_go && !stat_x.hit;
  assign ctrl_y.limit_n = in_word_r.limit_y_n;
  assign ctrl_z.start   = is_start;
  assign ctrl_z.serve   = run_go && !stat_x.hit && !stat_y.hit;
  assign ctrl_z.limit_n = in_word_r.limit_z_n;

  tspg_axis #(.POS_WIDTH(POS_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_axis_x (
    .clk(clk), .rst_n(rst_n), .ctrl_i(ctrl_x), .target_i(tgt_x), .period_i(per_x),
    .tick_clock_i(tick_clock_r), .stat_o(stat_x), .pos_o(pos_x)
  );

  tspg_axis #(.POS_WIDTH(POS_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_axis_y (
    .clk(clk), .rst_n(rst_n), .ctrl_i(ctrl_y), .target_i(tgt_y), .period_i(per_y),
    .tick_clock_i(tick_clock_r), .stat_o(stat_y), .pos_o(pos_y)
  );

  tspg_axis #(.POS_WIDTH(POS_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_axis_z (
    .clk(clk), .rst_n(rst_n), .ctrl_i(ctrl_z), .target_i(tgt_z), .period_i(per_z),
    .tick_clock_i(tick_clock_r), .stat_o(stat_z), .pos_o(pos_z)
  );

  assign hit_vec = {stat_z.hit, stat_y.hit, stat_x.hit};
  assign any_hit = |hit_vec;
  assign all_on  = stat_x.on_target && stat_y.on_target && stat_z.on_target;

  assign pos_x_ext = {32'b0, pos_x};
  assign pos_y_ext = {32'b0, pos_y};
  assign pos_z_ext = {32'b0, pos_z};

  // move flag, tick clock and result word
  always_comb begin
    move_active_nxt            = move_active_r;
    tick_clock_nxt             = tick_clock_r;
    out_word_nxt.status        = tspg_pkg::ST_IDLE;
    out_word_nxt.limit_axis    = tspg_pkg::AXIS_X;
    out_word_nxt.backoff_pulse = 1'b0;
    out_word_nxt.step_x        = stat_x.step;
    out_word_nxt.step_y        = stat_y.step;
    out_word_nxt.step_z        = stat_z.step;
    out_word_nxt.dir_x         = stat_x.dir;
    out_word_nxt.dir_y         = stat_y.dir;
    out_word_nxt.dir_z         = stat_z.dir;
    out_word_nxt.pos_x         = pos_x_ext[31:0];
    out_word_nxt.pos_y         = pos_y_ext[31:0];
    out_word_nxt.pos_z         = pos_z_ext[31:0];
    if (is_start) begin
      tick_clock_nxt      = '0;
      move_active_nxt     = !all_on;
      out_word_nxt.status = all_on ? tspg_pkg::ST_DONE : tspg_pkg::ST_RUN;
    end else if (is_tick && move_active_r) begin
      if (in_word_r.estop) begin
        move_active_nxt     = 1'b0;
        out_word_nxt.status = tspg_pkg::ST_ESTOP;
      end else if (any_hit) begin
        move_active_nxt            = 1'b0;
        out_word_nxt.status        = tspg_pkg::ST_LIMIT;
        out_word_nxt.backoff_pulse = 1'b1;
        if (stat_x.hit) begin
          out_word_nxt.limit_axis = tspg_pkg::AXIS_X;
        end else if (stat_y.hit) begin
          out_word_nxt.limit_axis = tspg_pkg::AXIS_Y;
        end else begin
          out_word_nxt.limit_axis = tspg_pkg::AXIS_Z;
        end
      end else begin
        tick_clock_nxt      = tick_clock_r + TIME_WIDTH'(1);
        move_active_nxt     = !all_on;
        out_word_nxt.status = all_on ? tspg_pkg::ST_DONE : tspg_pkg::ST_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_active_r <= 1'b0;
      tick_clock_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      move_active_r <= move_active_nxt;
      tick_clock_r  <= tick_clock_nxt;
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_word_r <= out_word_nxt;
    end
  end

  // checks
  `TSPG_ASSERT_IMP(a_one_hit, clk, rst_n, 1'b1, $onehot0(hit_vec), "two axes hit a limit")
  `TSPG_ASSERT_NXT(a_hit_stops, clk, rst_n, proc && any_hit, !move_active_r, "armed after a hit")
  `TSPG_ASSERT_NXT(a_hold_word, clk, rst_n, in_stall, in_valid_r && $stable(in_word_r), "word lost")
  `TSPG_ASSERT_NXT(a_hit_bo, clk, rst_n, proc && any_hit, out_word_r.backoff_pulse, "no back-off")

endmodule
